/* hw/rtl/lzss_pkg.sv */
// lzss_pkg: shared types, constants and command/status structs for the lzss stream decoder
// no dependencies
package lzss_pkg;

  localparam int HistAw = 16;
  localparam int HistDepth = 1 << HistAw;
  localparam int BytesPerResult = 8;
  localparam int CntW = 4;

  localparam logic [7:0] LongOffMark = 8'h80;
  localparam logic [1:0] StatData = 2'd0;
  localparam logic [1:0] StatEnd = 2'd1;
  localparam logic [1:0] StatErr = 2'd2;

  typedef enum logic [1:0] {
    PH_FLAG, PH_TOKEN, PH_OFF_LOW, PH_LENGTH
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_COPY_RD, S_COPY_WR, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [63:0]     out_bytes;
    logic [CntW-1:0] out_count;
    logic            last;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic take;     // process the accepted input item
    logic copy_rd;  // read one history byte
    logic copy_wr;  // write, pack and maybe emit one copied byte
  } lzss_cmd_t;

  typedef struct packed {
    logic start_copy;  // current item opens a non-empty copy
    logic last_byte;   // one copied byte remains
    logic fill;        // next packed byte fills the word
    logic out_free;    // output register can take a result
  } lzss_stat_t;

endpackage

/* hw/rtl/lzss_ctrl.sv */
// lzss_ctrl: controller state machine sequencing item intake and byte copies
// depends on lzss_pkg
module lzss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  lzss_pkg::in_item_t  in_item,
  output logic                in_stall,
  input  lzss_pkg::lzss_stat_t stat,
  output lzss_pkg::lzss_cmd_t cmd
);
  import lzss_pkg::*;

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.take = 1'b1;
          if (in_item.end_of_input) begin
            state_next = S_DONE;
          end else if (stat.start_copy) begin
            state_next = S_COPY_RD;
          end
        end
      end
      S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        // hold when a result is due and the output is still full
        if (!((stat.last_byte || stat.fill) && !stat.out_free)) begin
          cmd.copy_wr = 1'b1;
          state_next = stat.last_byte ? S_IDLE : S_COPY_RD;
        end
      end
      S_DONE: begin
        // items after the end are taken and dropped
        in_stall = 1'b0;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/lzss_dp.sv */
// lzss_dp: parse registers, history ring, byte packer and output register
// depends on lzss_pkg
module lzss_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lzss_pkg::in_item_t   in_item,
  input  lzss_pkg::lzss_cmd_t  cmd,
  output lzss_pkg::lzss_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lzss_pkg::out_item_t  out_item
);
  import lzss_pkg::*;

  logic [7:0]        hist [HistDepth];
  phase_t            phase;
  logic [7:0]        flags;
  logic [2:0]        tok_num;
  logic [14:0]       pend_off;
  logic [HistAw-1:0] wp;
  logic              wrapped;
  logic [HistAw-1:0] back;
  logic [7:0]        remain;
  logic [63:0]       acc;
  logic [CntW-1:0]   cnt;
  logic [7:0]        rd_data;
  logic              rd_zero;

  logic              ref_bit;
  logic [7:0]        b;
  logic [7:0]        cp_byte;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic              emit;
  out_item_t         emit_item;
  logic              tok_last;

  assign b = in_item.in_byte;
  assign ref_bit = flags[tok_num];
  assign tok_last = (tok_num == 3'd7);
  assign cp_byte = rd_zero ? 8'd0 : rd_data;

  assign stat.start_copy = !in_item.end_of_input && phase == PH_LENGTH && b != 8'd0;
  assign stat.last_byte = (remain == 8'd1);
  assign stat.fill = (cnt == CntW'(BytesPerResult - 1));
  assign stat.out_free = !out_valid || !out_stall;

  // memory write and result selection
  always_comb begin
    wr_en = 1'b0;
    wr_data = b;
    emit = 1'b0;
    emit_item = '0;
    if (cmd.take) begin
      if (in_item.end_of_input) begin
        emit = 1'b1;
        emit_item.last = 1'b1;
        emit_item.status = (phase == PH_OFF_LOW || phase == PH_LENGTH ||
                            (phase == PH_TOKEN && ref_bit)) ? StatErr : StatEnd;
      end else if (phase == PH_TOKEN && !ref_bit) begin
        wr_en = 1'b1;
        emit = 1'b1;
        emit_item.out_bytes = {56'd0, b};
        emit_item.out_count = CntW'(1);
        emit_item.last = 1'b1;
        emit_item.status = StatData;
      end
    end else if (cmd.copy_wr) begin
      wr_en = 1'b1;
      wr_data = cp_byte;
      emit = stat.last_byte || stat.fill;
      emit_item.out_bytes = acc | (64'(cp_byte) << {cnt[2:0], 3'b000});
      emit_item.out_count = cnt + CntW'(1);
      emit_item.last = stat.last_byte;
      emit_item.status = StatData;
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wp] <= wr_data;
    end
    if (cmd.copy_rd) begin
      rd_data <= hist[back];
    end
  end

  // never-written slots read as zero until the ring has wrapped
  always_ff @(posedge clk) begin
    if (cmd.copy_rd) begin
      rd_zero <= !wrapped && back >= wp;
    end
  end

  // parse state, write pointer and packer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAG;
      flags <= '0;
      tok_num <= '0;
      pend_off <= '0;
      wp <= '0;
      wrapped <= 1'b0;
      remain <= '0;
      acc <= '0;
      cnt <= '0;
      back <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + HistAw'(1);
        if (wp == '1) begin
          wrapped <= 1'b1;
        end
      end
      if (cmd.take && !in_item.end_of_input) begin
        case (phase)
          PH_FLAG: begin
            flags <= b;
            tok_num <= '0;
            phase <= PH_TOKEN;
          end
          PH_TOKEN: begin
            if (ref_bit) begin
              if (b < LongOffMark) begin
                pend_off <= {7'd0, b};
                phase <= PH_LENGTH;
              end else begin
                pend_off <= {b[6:0], 8'd0};
                phase <= PH_OFF_LOW;
              end
            end else begin
              tok_num <= tok_num + 3'd1;
              phase <= tok_last ? PH_FLAG : PH_TOKEN;
            end
          end
          PH_OFF_LOW: begin
            pend_off <= {pend_off[14:8], b};
            phase <= PH_LENGTH;
          end
          PH_LENGTH: begin
            back <= wp - HistAw'(pend_off);
            remain <= b;
            acc <= '0;
            cnt <= '0;
            if (b == 8'd0) begin
              tok_num <= tok_num + 3'd1;
              phase <= tok_last ? PH_FLAG : PH_TOKEN;
            end
          end
          default: begin
            phase <= PH_FLAG;
          end
        endcase
      end
      if (cmd.copy_rd) begin
        back <= back + HistAw'(1);
      end
      if (cmd.copy_wr) begin
        remain <= remain - 8'd1;
        if (emit) begin
          acc <= '0;
          cnt <= '0;
        end else begin
          acc <= emit_item.out_bytes;
          cnt <= emit_item.out_count;
        end
        if (stat.last_byte) begin
          tok_num <= tok_num + 3'd1;
          phase <= tok_last ? PH_FLAG : PH_TOKEN;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
  end

endmodule

/* hw/rtl/lzss_stream_decoder.sv */
// lzss_stream_decoder: top level, controller plus datapath with a 64 KiB history ring
// flag, offset, literal and zero-length items are taken one per cycle while the output
// register can take a result; a literal or end item gives its result in the next cycle;
// a copy does one history read and one history write per byte through the single-port ring
// reset clears control and datapath state but not the ring; unwritten ring slots read as zero by fill tracking
module lzss_stream_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lzss_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lzss_pkg::out_item_t out_item
);
  import lzss_pkg::*;

  lzss_cmd_t  cmd;
  lzss_stat_t stat;

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a result never carries more bytes than a word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.out_count <= CntW'(BytesPerResult))
    else $error("result byte count too large");

  // a status-only result closes the item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_count == '0 |-> out_item.last && out_item.status != StatData)
    else $error("empty result without end status");

  // a data result is never empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == StatData |-> out_item.out_count != '0)
    else $error("empty data result");

  // at most one command issued per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.copy_rd, cmd.copy_wr}))
    else $error("conflicting datapath commands");

endmodule

/* bench/lzss_stream_decoder_tb.sv */
// lzss_stream_decoder_tb: self-checking bench for the lzss stream decoder
// depends on lzss_pkg and lzss_stream_decoder; predicts results and scores each output item
`timescale 1ns / 1ps

class lzss_scoreboard;
  logic [7:0] ring [0:65535];
  logic [15:0] wr_pos;
  logic [7:0] flags;
  logic [2:0] tok_num;
  lzss_pkg::phase_t phase;
  logic [14:0] offset;
  bit finished;
  lzss_pkg::out_item_t pending_q[$];
  int errors;

  function new();
    for (int i = 0; i < 65536; i++) ring[i] = 8'h00;
    wr_pos = '0;
    flags = '0;
    tok_num = '0;
    phase = lzss_pkg::PH_FLAG;
    offset = '0;
    finished = 0;
    errors = 0;
  endfunction

  // advance to the next token or flag byte
  function void step_token();
    if (tok_num == 3'd7) begin
      tok_num = '0;
      phase = lzss_pkg::PH_FLAG;
    end else begin
      tok_num++;
      phase = lzss_pkg::PH_TOKEN;
    end
  endfunction

  // pack one produced byte, flushing a full word
  function void pack(input logic [7:0] b, ref logic [63:0] acc, ref int cnt,
                     ref lzss_pkg::out_item_t res_q[$]);
    lzss_pkg::out_item_t r;
    acc[8*cnt +: 8] = b;
    cnt++;
    if (cnt == 8) begin
      r = '{out_bytes: acc, out_count: 4'(cnt), last: 1'b0, status: lzss_pkg::StatData};
      res_q.push_back(r);
      acc = '0;
      cnt = 0;
    end
  endfunction

  // note an accepted input item and queue its results
  function void note_input(lzss_pkg::in_item_t it);
    lzss_pkg::out_item_t res_q[$];
    lzss_pkg::out_item_t r;
    logic [63:0] acc;
    int cnt;
    logic [15:0] back;
    logic [7:0] v;
    bit is_ref;
    acc = '0;
    cnt = 0;
    is_ref = flags[tok_num];
    if (finished) return;
    if (it.end_of_input) begin
      r = '{out_bytes: '0, out_count: '0, last: 1'b1, status: lzss_pkg::StatEnd};
      if (phase == lzss_pkg::PH_OFF_LOW || phase == lzss_pkg::PH_LENGTH ||
          (phase == lzss_pkg::PH_TOKEN && is_ref))
        r.status = lzss_pkg::StatErr;
      pending_q.push_back(r);
      finished = 1;
      return;
    end
    case (phase)
      lzss_pkg::PH_FLAG: begin
        flags = it.in_byte;
        tok_num = '0;
        phase = lzss_pkg::PH_TOKEN;
      end
      lzss_pkg::PH_TOKEN: begin
        if (is_ref) begin
          if (it.in_byte < lzss_pkg::LongOffMark) begin
            offset = {8'h00, it.in_byte[6:0]};
            phase = lzss_pkg::PH_LENGTH;
          end else begin
            offset = {it.in_byte[6:0], 8'h00};
            phase = lzss_pkg::PH_OFF_LOW;
          end
        end else begin
          ring[wr_pos] = it.in_byte;
          wr_pos++;
          pack(it.in_byte, acc, cnt, res_q);
          step_token();
        end
      end
      lzss_pkg::PH_OFF_LOW: begin
        offset[7:0] = it.in_byte;
        phase = lzss_pkg::PH_LENGTH;
      end
      default: begin
        back = wr_pos - {1'b0, offset};
        for (int i = 0; i < it.in_byte; i++) begin
          v = ring[back];
          ring[wr_pos] = v;
          wr_pos++;
          pack(v, acc, cnt, res_q);
          back++;
        end
        step_token();
      end
    endcase
    if (cnt > 0) begin
      r = '{out_bytes: acc, out_count: 4'(cnt), last: 1'b0, status: lzss_pkg::StatData};
      res_q.push_back(r);
    end
    if (res_q.size() > 0) res_q[res_q.size()-1].last = 1'b1;
    foreach (res_q[i]) pending_q.push_back(res_q[i]);
  endfunction

  // compare a result item with the oldest expectation
  function void check_result(lzss_pkg::out_item_t got);
    lzss_pkg::out_item_t exp_r;
    if (pending_q.size() == 0) begin
      $error("unexpected result item %h", got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.out_bytes !== exp_r.out_bytes) begin
      $error("out_bytes exp %h got %h", exp_r.out_bytes, got.out_bytes);
      errors++;
    end
    if (got.out_count !== exp_r.out_count) begin
      $error("out_count exp %0d got %0d", exp_r.out_count, got.out_count);
      errors++;
    end
    if (got.last !== exp_r.last) begin
      $error("last exp %0d got %0d", exp_r.last, got.last);
      errors++;
    end
    if (got.status !== exp_r.status) begin
      $error("status exp %0d got %0d", exp_r.status, got.status);
      errors++;
    end
  endfunction
endclass

module lzss_stream_decoder_tb;
  import lzss_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  lzss_scoreboard sb;
  bit calm = 0;      // no idling on either side while set
  int sent = 0;

  lzss_stream_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // send one item, with a random gap in front; called at a rising edge
  task automatic send_item(input logic [7:0] b, input logic eoi);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{in_byte: b, end_of_input: eoi};
    do @(posedge clk); while (in_stall);
    sb.note_input('{in_byte: b, end_of_input: eoi});
    sent++;
  endtask

  // send a byte, never the end mark
  task automatic send_byte(input logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  // one random group: flag then eight tokens, small lengths mostly
  task automatic send_group(input bit broken);
    logic [7:0] f;
    f = 8'($urandom);
    send_byte(f);
    for (int t = 0; t < 8; t++) begin
      if (broken && $urandom_range(9) == 0) begin
        send_byte(8'($urandom));
      end else if (!f[t]) begin
        send_byte(8'($urandom));
      end else begin
        if ($urandom_range(3) == 0) begin
          send_byte(8'($urandom_range(255, 128)));
          send_byte(8'($urandom));
        end else begin
          send_byte(8'($urandom_range(127)));
        end
        if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255, 200)));
        else send_byte(8'($urandom_range(20)));
      end
    end
  endtask

  // wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // output side: random stall, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      out_stall <= !calm && ($urandom_range(99) < 19);
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: literals at extremes, short and long offsets, overlap, zero length
    send_byte(8'b0111_1100);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h01);          // offset one, overlapping copy
    send_byte(8'd20);
    send_byte(8'h7f);          // offset reaching before the start
    send_byte(8'd9);
    send_byte(8'h80);          // long offset zero: reads own slot
    send_byte(8'h00);
    send_byte(8'd3);
    send_byte(8'hff);          // long offset wraps the ring
    send_byte(8'hff);
    send_byte(8'd255);
    send_byte(8'h05);          // zero length reference
    send_byte(8'd0);
    send_byte(8'h5a);          // closing literal of the group
    drain();

    // long stretch with no idling
    calm = 1;
    repeat (8) send_group(0);
    drain();
    calm = 0;

    // random groups, the odd one broken
    while (sent < 450) send_group($urandom_range(7) == 0);

    // end inside a back reference, then ignored input
    send_byte(8'hff);
    send_byte(8'h81);
    send_item(8'($urandom), 1'b1);
    send_byte(8'($urandom));
    send_item(8'h00, 1'b1);

    drain();
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("lzss_stream_decoder_tb OK");
    end else begin
      $display("lzss_stream_decoder_tb NOT OK");
    end
    $finish;
  end

  // generous overall limit
  initial begin
    #4000000;
    $display("lzss_stream_decoder_tb NOT OK");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_ctrl.sv
hw/rtl/lzss_dp.sv
hw/rtl/lzss_stream_decoder.sv
bench/lzss_stream_decoder_tb.sv
